[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the box blur RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define BB3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bb3_pkg.sv]
// ---------------------------------------------------------------------------
// bb3_pkg
// Types, sizes and helper functions shared by the box blur modules.
// ---------------------------------------------------------------------------
package bb3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 13;
	localparam int OUT_ROW_W = 12;
	localparam int IN_ROW_W  = 13;

	localparam int CHAN_W    = 8;
	localparam int CHANNELS  = 4;
	localparam int PIX_W     = CHAN_W * CHANNELS;
	localparam int LINE_W    = 2 * PIX_W;
	localparam int WIN_SIZE  = 9;

	localparam int SUM_W     = 12;
	localparam int CNT_W     = 4;
	localparam int RECIP_W   = 17;
	localparam int RECIP_SH  = 16;
	localparam int PROD_W    = SUM_W + RECIP_W;

	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 3;
	localparam int REG_SEL_BIT = 2;

	// register index codes
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1);

	typedef logic [PIX_W-1:0] pixel_t;
	typedef pixel_t [WIN_SIZE-1:0] window_t;
	typedef logic [CHANNELS-1:0][CHAN_W-1:0] chan_vec_t;

	typedef struct packed {
		logic [CHAN_W-1:0] in_red;
		logic [CHAN_W-1:0] in_green;
		logic [CHAN_W-1:0] in_blue;
		logic [CHAN_W-1:0] in_alpha;
		logic              drain;
	} pix_beat_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_alpha;
		logic              frame_end;
	} res_beat_t;

	typedef struct packed {
		logic [WIDTH_W-1:0]  width;
		logic [HEIGHT_W-1:0] height;
		logic                restart;
	} cfg_t;

	// which border rows and columns of the window lie inside the frame
	typedef struct packed {
		logic row_top;
		logic row_bot;
		logic col_left;
		logic col_right;
	} win_mask_t;

	// ceil(2^16 / n): exact floor division for sums up to 9*255
	function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] r;
		case (cnt)
			4'd2:    r = RECIP_W'(32768);
			4'd3:    r = RECIP_W'(21846);
			4'd4:    r = RECIP_W'(16384);
			4'd6:    r = RECIP_W'(10923);
			4'd9:    r = RECIP_W'(7282);
			default: r = RECIP_W'(65536);
		endcase
		return r;
	endfunction

endpackage

[rtl/bb3_line_mem.sv]
// ---------------------------------------------------------------------------
// bb3_line_mem
// Two-line pixel store: one entry per column holds the upper and lower line.
// ---------------------------------------------------------------------------
module bb3_line_mem (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [bb3_pkg::COL_W-1:0]  rd_addr,
	output logic [bb3_pkg::LINE_W-1:0] rd_data,
	input  logic                       wr_en,
	input  logic [bb3_pkg::COL_W-1:0]  wr_addr,
	input  logic [bb3_pkg::LINE_W-1:0] wr_data
);
	import bb3_pkg::*;

	logic [LINE_W-1:0] mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/bb3_cfg.sv]
// ---------------------------------------------------------------------------
// bb3_cfg
// APB register file for frame width and height, with range clamping.
// ---------------------------------------------------------------------------
module bb3_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bb3_pkg::PADDR_W-1:0]    paddr,
	input  logic [bb3_pkg::APB_DATA_W-1:0] pwdata,
	output logic [bb3_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output bb3_pkg::cfg_t                  cfg
);
	import bb3_pkg::*;

	logic                wr;
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [WIDTH_W-1:0]  width_in;
	logic [HEIGHT_W-1:0] height_in;
	logic [WIDTH_W-1:0]  width_clamped;
	logic [HEIGHT_W-1:0] height_clamped;

	assign pready    = 1'b1;
	assign wr        = psel && penable && pwrite;
	assign width_in  = pwdata[WIDTH_W-1:0];
	assign height_in = pwdata[HEIGHT_W-1:0];

	always_comb begin
		if (width_in == '0) begin
			width_clamped = WIDTH_W'(1);
		end else if (width_in > WIDTH_W'(MAX_WIDTH)) begin
			width_clamped = WIDTH_W'(MAX_WIDTH);
		end else begin
			width_clamped = width_in;
		end
		if (height_in == '0) begin
			height_clamped = HEIGHT_W'(1);
		end else if (height_in > HEIGHT_W'(MAX_HEIGHT)) begin
			height_clamped = HEIGHT_W'(MAX_HEIGHT);
		end else begin
			height_clamped = height_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RESET;
			height_q  <= HEIGHT_RESET;
		end else begin
			if (wr) begin
				case (paddr[REG_SEL_BIT])
					REG_IMAGE_WIDTH:  width_q  <= width_clamped;
					REG_IMAGE_HEIGHT: height_q <= height_clamped;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (paddr[REG_SEL_BIT])
			REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_q);
			default:          prdata = '0;
		endcase
	end

	// restart acts at the write edge itself, together with the new value
	assign cfg.width   = width_q;
	assign cfg.height  = height_q;
	assign cfg.restart = wr;

endmodule

[rtl/bb3_avg.sv]
// ---------------------------------------------------------------------------
// bb3_avg
// Masked 3x3 channel sums, then floor division by a reciprocal multiply.
// ---------------------------------------------------------------------------
module bb3_avg (
	input  logic                clk,
	input  logic                load,
	input  bb3_pkg::window_t    win,
	input  bb3_pkg::win_mask_t  mask,
	output bb3_pkg::chan_vec_t  avg
);
	import bb3_pkg::*;

	logic [2:0][SUM_W-1:0]          row_sum;
	logic [CHANNELS-1:0][SUM_W-1:0] sum_c;
	logic [1:0]                     n_rows;
	logic [1:0]                     n_cols;
	logic [CNT_W-1:0]               cnt;
	logic [CHANNELS-1:0][SUM_W-1:0] sum_s1;
	logic [RECIP_W-1:0]             recip_s1;
	logic [CHANNELS-1:0][PROD_W-1:0] prod;

	always_comb begin
		row_sum = '0;
		sum_c   = '0;
		for (int k = 0; k < CHANNELS; k++) begin
			for (int r = 0; r < 3; r++) begin
				row_sum[r] = SUM_W'(win[3*r+1][CHAN_W*k +: CHAN_W]);
				if (mask.col_left) begin
					row_sum[r] = row_sum[r] + SUM_W'(win[3*r][CHAN_W*k +: CHAN_W]);
				end
				if (mask.col_right) begin
					row_sum[r] = row_sum[r] + SUM_W'(win[3*r+2][CHAN_W*k +: CHAN_W]);
				end
			end
			sum_c[k] = row_sum[1];
			if (mask.row_top) begin
				sum_c[k] = sum_c[k] + row_sum[0];
			end
			if (mask.row_bot) begin
				sum_c[k] = sum_c[k] + row_sum[2];
			end
		end
	end

	assign n_rows = 2'd1 + 2'(mask.row_top) + 2'(mask.row_bot);
	assign n_cols = 2'd1 + 2'(mask.col_left) + 2'(mask.col_right);
	assign cnt    = CNT_W'(n_rows) * CNT_W'(n_cols);

	always_ff @(posedge clk) begin
		if (load) begin
			sum_s1   <= sum_c;
			recip_s1 <= recip_of(cnt);
		end
	end

	always_comb begin
		for (int k = 0; k < CHANNELS; k++) begin
			prod[k] = PROD_W'(sum_s1[k]) * PROD_W'(recip_s1);
			avg[k]  = prod[k][RECIP_SH +: CHAN_W];
		end
	end

endmodule

[rtl/box_blur_3x3_core.sv]
// ---------------------------------------------------------------------------
// box_blur_3x3_core
// 3x3 box blur over an RGBA raster stream with per-frame size registers.
// ---------------------------------------------------------------------------
// An accepted pixel beat that produces a result passes through, in order:
// ST_IDLE issues the line memory read, ST_RD shifts the window and writes
// the column back, ST_SUM forms the masked channel sums and ST_OUT divides
// and loads the output register. A beat that produces no result (the first
// line and the first pixel of the second line) leaves after the write-back.
// The next beat enters only back in ST_IDLE, so the read-modify-write of
// the single-port-per-direction line memory never overlaps. A drain beat
// sent while the frame still owes pixels is dropped. The output register
// holds a finished result while the next beat is taken, so the result
// side can stall until that beat reaches ST_OUT without slowing input.
// Results trail the input by one line plus one pixel; send
// image_width+1 drain beats after a frame to flush it. No clearing pass runs
// after reset. Any register write restarts the frame at the write edge.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module box_blur_3x3_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// pixel input channel
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  bb3_pkg::pix_beat_t             pix,
	// result channel
	output logic                           res_valid,
	input  logic                           res_stall,
	output bb3_pkg::res_beat_t             res,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bb3_pkg::PADDR_W-1:0]    paddr,
	input  logic [bb3_pkg::APB_DATA_W-1:0] pwdata,
	output logic [bb3_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import bb3_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RD   = 4'b0010,
		ST_SUM  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q;

	cfg_t cfg;

	// frame position of the next beat and of the next result
	logic [COL_W-1:0]     in_col_q;
	logic [IN_ROW_W-1:0]  in_row_q;
	logic [COL_W-1:0]     out_col_q;
	logic [OUT_ROW_W-1:0] out_row_q;

	logic          pix_accept;
	logic          drain_phase;
	logic          skip;
	logic          start;
	pixel_t        pix_q;
	window_t       window_q;
	win_mask_t     mask_q;
	logic          last_q;

	logic [LINE_W-1:0] rd_data;
	logic              wr_en;
	logic [LINE_W-1:0] wr_data;

	logic              emit;
	logic              last;
	logic [WIDTH_W-1:0]  in_col_inc;
	logic [WIDTH_W-1:0]  out_col_inc;
	logic [HEIGHT_W-1:0] out_row_inc;
	win_mask_t         mask_d;

	chan_vec_t avg;
	logic      avg_load;
	logic      out_load;
	res_beat_t res_q;
	logic      res_valid_q;

	bb3_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input side: take a beat only when the engine is free.
	assign pix_stall   = (state_q != ST_IDLE);
	assign pix_accept  = pix_valid && !pix_stall;
	assign drain_phase = (in_row_q >= cfg.height);
	// a drain beat while pixels are still owed is dropped without effect
	assign skip        = !drain_phase && pix.drain;
	assign start       = pix_accept && !skip;

	// Line memory: entry per column, upper line in the high half.
	// Read on start, write back in ST_RD; the FSM holds off the next read
	// until then, so the same column is never read stale.
	assign wr_en   = (state_q == ST_RD);
	assign wr_data = {rd_data[PIX_W-1:0], pix_q};

	bb3_line_mem u_line_mem (
		.clk     (clk),
		.rd_en   (start),
		.rd_addr (in_col_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (in_col_q),
		.wr_data (wr_data)
	);

	// Result bookkeeping for the beat in ST_RD.
	assign emit = (in_row_q >= IN_ROW_W'(2)) ||
		((in_row_q == IN_ROW_W'(1)) && (in_col_q != '0));
	assign in_col_inc  = WIDTH_W'(in_col_q) + WIDTH_W'(1);
	assign out_col_inc = WIDTH_W'(out_col_q) + WIDTH_W'(1);
	assign out_row_inc = HEIGHT_W'(out_row_q) + HEIGHT_W'(1);
	assign last = (out_col_inc >= cfg.width) && (out_row_inc >= cfg.height);

	// Neighbors outside the frame drop out of both sum and divisor.
	assign mask_d.row_top   = (out_row_q != '0);
	assign mask_d.row_bot   = (out_row_inc < cfg.height);
	assign mask_d.col_left  = (out_col_q != '0);
	assign mask_d.col_right = (out_col_inc < cfg.width);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= emit ? ST_SUM : ST_IDLE;
				end
				ST_SUM: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Position counters: advance input every ST_RD, output on each result;
	// the result with frame_end and any register write restart the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg.restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (state_q == ST_RD) begin
			if (emit && last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_inc >= cfg.width) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + IN_ROW_W'(1);
				end else begin
					in_col_q <= in_col_inc[COL_W-1:0];
				end
				if (emit) begin
					if (out_col_inc >= cfg.width) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + OUT_ROW_W'(1);
					end else begin
						out_col_q <= out_col_inc[COL_W-1:0];
					end
				end
			end
		end
	end

	// Payload: captured pixel, sliding window, result flags.
	always_ff @(posedge clk) begin
		if (start) begin
			pix_q <= drain_phase ? '0 : {pix.in_alpha, pix.in_blue, pix.in_green, pix.in_red};
		end
		if (state_q == ST_RD) begin
			for (int r = 0; r < 3; r++) begin
				window_q[3*r]   <= window_q[3*r+1];
				window_q[3*r+1] <= window_q[3*r+2];
			end
			window_q[2] <= rd_data[LINE_W-1:PIX_W];
			window_q[5] <= rd_data[PIX_W-1:0];
			window_q[8] <= pix_q;
			mask_q      <= mask_d;
			last_q      <= last;
		end
	end

	assign avg_load = (state_q == ST_SUM);

	bb3_avg u_avg (
		.clk  (clk),
		.load (avg_load),
		.win  (window_q),
		.mask (mask_q),
		.avg  (avg)
	);

	// Output register: load when empty or being drained this cycle.
	assign out_load = (state_q == ST_OUT) && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q.out_red   <= avg[0];
			res_q.out_green <= avg[1];
			res_q.out_blue  <= avg[2];
			res_q.out_alpha <= avg[3];
			res_q.frame_end <= last_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Never overwrite a result that is still held by a stall.
	`BB3_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_load, !(res_valid_q && res_stall), "output register overwritten while stalled")
	// A beat that is not dropped goes straight to the memory write-back.
	`BB3_ASSERT_NEXT(a_start_to_rd, clk, arst_n, start, state_q == ST_RD, "accepted beat did not reach write-back")
	// The frame-end result leaves every position counter at zero.
	`BB3_ASSERT_NEXT(a_frame_restart, clk, arst_n, (state_q == ST_RD) && emit && last, (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0), "frame end did not restart counters")
	// Input row never runs far past the frame while draining.
	`BB3_ASSERT_NOW(a_row_bound, clk, arst_n, 1'b1, (14'(in_row_q) <= (14'(cfg.height) + 14'd2)), "input row ran past the drain window")

endmodule

[verif/tb_box_blur_3x3_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_box_blur_3x3_core
// Self-checking bench for the 3x3 RGBA box blur. A directed table covers
// the size extremes, flush behavior and frame restarts. Random frames of
// random size follow, with random sender gaps and result stalls. Every
// result beat is checked against an in-bench model of the blur.
// ---------------------------------------------------------------------------
module tb_box_blur_3x3_core;
	import bb3_pkg::*;

	localparam int RANDOM_BEATS   = 1600;
	localparam int SETTLE_CYCLES  = 16;    // a few beats of block latency
	localparam int DRAIN_CYCLES   = 40;
	localparam int STALL_PCT      = 27;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 50;
	localparam int WIDE_FLUSH     = 64;    // part of the flush of the widest line
	localparam int TALL_PIXELS    = 200;   // first lines of the tallest frame

	typedef enum logic [1:0] {STEP_BEAT, STEP_WRITE, STEP_READ} step_kind_t;

	// One row of the directed plan. For writes, value is the register data.
	// For reads, value is the expected read-back. For beats with typed set,
	// want is the result beat that this beat must push out.
	typedef struct packed {
		step_kind_t  kind;
		logic        reg_idx;
		logic [31:0] value;
		pix_beat_t   beat;
		logic        typed;
		res_beat_t   want;
	} plan_row_t;

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_stall;
	pix_beat_t             pix     = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	res_beat_t             res;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [PADDR_W-1:0]    paddr   = '0;
	logic [APB_DATA_W-1:0] pwdata  = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// Blur model state: the two previous lines, the 3x3 window, the
	// position of the next input beat and of the next result, the geometry.
	pixel_t      line_far  [MAX_WIDTH] = '{default: '0};
	pixel_t      line_near [MAX_WIDTH] = '{default: '0};
	pixel_t      win       [WIN_SIZE]  = '{default: '0};
	int unsigned feed_col  = 0;
	int unsigned feed_row  = 0;
	int unsigned emit_col  = 0;
	int unsigned emit_row  = 0;
	int unsigned frame_w   = WIDTH_RESET;
	int unsigned frame_h   = HEIGHT_RESET;

	res_beat_t   due_results [$];
	res_beat_t   next_want;
	int unsigned bad_fields   = 0;
	int unsigned quiet_cycles = 0;
	bit          calm         = 1'b0;   // suppress all gaps and stalls

	// Directed plan. Expected results are typed in only for the one-pixel
	// and two-pixel frames, where every output is plainly the pixel itself
	// or the mean of the two.
	plan_row_t directed_plan [31] = '{
		// reset values read back
		'{STEP_READ,  REG_IMAGE_WIDTH,  32'd1024, 33'd0, 1'b0, 33'd0},
		'{STEP_READ,  REG_IMAGE_HEIGHT, 32'd1,    33'd0, 1'b0, 33'd0},
		// zero sizes clamp to a 1x1 frame; upper data bits are ignored
		'{STEP_WRITE, REG_IMAGE_WIDTH,  32'hFFFF_F800, 33'd0, 1'b0, 33'd0},
		'{STEP_WRITE, REG_IMAGE_HEIGHT, 32'h8000_0000, 33'd0, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0}, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1},
			1'b1, {8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1}},
		// drain at the start of a frame is dropped
		'{STEP_BEAT,  1'b0, 32'd0, {8'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, 33'd0},
		// 2x1 frame: both outputs average black and white
		'{STEP_WRITE, REG_IMAGE_WIDTH,  32'd2, 33'd0, 1'b0, 33'd0},
		'{STEP_READ,  REG_IMAGE_WIDTH,  32'd2, 33'd0, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'h00, 8'h00, 8'h00, 8'h00, 1'b1},
			1'b1, {8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b0}},
		// a pixel past the end of the frame flushes like a drain
		'{STEP_BEAT,  1'b0, 32'd0, {8'h5A, 8'hA5, 8'h3C, 8'hC3, 1'b0},
			1'b1, {8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b1}},
		// 3x2 frame, restarted by a height write after two pixels
		'{STEP_WRITE, REG_IMAGE_WIDTH,  32'd3, 33'd0, 1'b0, 33'd0},
		'{STEP_WRITE, REG_IMAGE_HEIGHT, 32'd2, 33'd0, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'h12, 8'h34, 8'h56, 8'h78, 1'b0}, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'h9A, 8'hBC, 8'hDE, 8'hF0, 1'b0}, 1'b0, 33'd0},
		'{STEP_WRITE, REG_IMAGE_HEIGHT, 32'd2, 33'd0, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0}, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'h00, 8'hFF, 8'h00, 8'h80, 1'b0}, 1'b0, 33'd0},
		// drain in the middle of the pixels is dropped
		'{STEP_BEAT,  1'b0, 32'd0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'h00, 8'h00, 8'hFF, 8'h7F, 1'b0}, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'hFF, 8'hFF, 8'hFF, 8'h01, 1'b0}, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'h80, 8'h40, 8'h20, 8'h10, 1'b0}, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'h01, 8'h02, 8'h03, 8'hFE, 1'b0}, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'hC0, 8'hC0, 8'hC0, 8'hC0, 1'b0}, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, 33'd0},
		'{STEP_BEAT,  1'b0, 32'd0, {8'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, 33'd0}
	};

	box_blur_3x3_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Count and report one mismatch; cap the printout on a badly broken run.
	function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
		bad_fields++;
		if (bad_fields <= REPORT_LIMIT)
			$display("%0t ns: %s expected %h, got %h", $time, what, want, got);
	endfunction

	function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
		if (got !== want)
			flag_mismatch(what, want, got);
	endfunction

	function automatic int unsigned clamp_size(int unsigned v, int unsigned top);
		return (v == 0) ? 1 : ((v > top) ? top : v);
	endfunction

	function automatic void rewind_frame();
		feed_col = 0;
		feed_row = 0;
		emit_col = 0;
		emit_row = 0;
	endfunction

	// Advance the blur model by one accepted pixel beat. Returns 1 and the
	// result beat when the beat pushes a window centre out.
	function automatic bit blur_step(input pix_beat_t b, output res_beat_t r);
		pixel_t      fresh;
		pixel_t      column [3];
		pixel_t      v;
		int unsigned xi;
		int unsigned taps;
		int unsigned chan_sum [CHANNELS];
		bit          in_frame;
		bit          emit;
		bit          last;
		r = '0;
		in_frame = (feed_row < frame_h);
		// drop a drain while the frame still owes pixels
		if (in_frame && b.drain)
			return 1'b0;
		// past the last pixel every beat flushes, its channels unused
		fresh = in_frame ? {b.in_alpha, b.in_blue, b.in_green, b.in_red} : '0;
		xi = (feed_col < MAX_WIDTH) ? feed_col : MAX_WIDTH - 1;
		column[0] = line_far[xi];
		column[1] = line_near[xi];
		column[2] = fresh;
		for (int rr = 0; rr < 3; rr++) begin
			win[3*rr]     = win[3*rr + 1];
			win[3*rr + 1] = win[3*rr + 2];
			win[3*rr + 2] = column[rr];
		end
		line_far[xi]  = column[1];
		line_near[xi] = fresh;

		// output trails the input by one line plus one pixel
		emit = (feed_row >= 2) || (feed_row == 1 && feed_col >= 1);
		feed_col++;
		if (feed_col >= frame_w) begin
			feed_col = 0;
			feed_row++;
		end
		if (!emit)
			return 1'b0;

		// average only the taps that lie inside the frame
		taps = 0;
		for (int k = 0; k < CHANNELS; k++)
			chan_sum[k] = 0;
		for (int rr = 0; rr < 3; rr++) begin
			for (int cc = 0; cc < 3; cc++) begin
				if (emit_row + rr >= 1 && emit_row + rr <= frame_h &&
				    emit_col + cc >= 1 && emit_col + cc <= frame_w) begin
					v = win[3*rr + cc];
					for (int k = 0; k < CHANNELS; k++)
						chan_sum[k] += v[CHAN_W*k +: CHAN_W];
					taps++;
				end
			end
		end
		if (taps == 0)
			taps = 1;
		r.out_red   = CHAN_W'(chan_sum[0] / taps);
		r.out_green = CHAN_W'(chan_sum[1] / taps);
		r.out_blue  = CHAN_W'(chan_sum[2] / taps);
		r.out_alpha = CHAN_W'(chan_sum[3] / taps);

		last = (emit_col + 1 >= frame_w) && (emit_row + 1 >= frame_h);
		r.frame_end = last;
		if (last) begin
			rewind_frame();
		end else begin
			emit_col++;
			if (emit_col >= frame_w) begin
				emit_col = 0;
				emit_row++;
			end
		end
		return 1'b1;
	endfunction

	// Random size: zero now and then (clamps to 1), mostly small, a few wider.
	function automatic int unsigned pick_size(int unsigned common_top, int unsigned rare_top);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return 0;
		if (roll < 88)
			return $urandom_range(1, common_top);
		return $urandom_range(common_top + 1, rare_top);
	endfunction

	// Hold the input idle until every expected result is out, then let the
	// block finish any beat that produced nothing.
	task automatic settle_idle(input int unsigned cycles);
		pix_valid = 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (cycles) @(negedge clk);
	endtask

	// Setup then access; the register takes the data at the edge that closes
	// the access phase.
	task automatic write_reg(input logic idx, input logic [31:0] value);
		settle_idle(SETTLE_CYCLES);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = PADDR_W'(idx) << REG_SEL_BIT;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		pwdata  = $urandom;
		if (idx == REG_IMAGE_WIDTH)
			frame_w = clamp_size(value[WIDTH_W-1:0], MAX_WIDTH);
		else
			frame_h = clamp_size(value[HEIGHT_W-1:0], MAX_HEIGHT);
		rewind_frame();
	endtask

	task automatic read_reg(input logic idx, input logic [31:0] want);
		logic [31:0] mask;
		mask = (idx == REG_IMAGE_WIDTH) ? 32'h0000_07FF : 32'h0000_1FFF;
		pix_valid = 1'b0;
		psel    = 1'b1;
		pwrite  = 1'b0;
		penable = 1'b0;
		paddr   = PADDR_W'(idx) << REG_SEL_BIT;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if ((prdata & mask) !== want)
			flag_mismatch("register read-back", want, prdata & mask);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Offer one pixel beat after a random gap, hold it through stalls, and
	// queue what it should produce. Valid stays high for a following beat.
	task automatic send_beat(input pix_beat_t b, input logic typed, input res_beat_t want);
		res_beat_t predicted;
		bit        made;
		while (!calm && $urandom_range(99) < STALL_PCT) begin
			pix_valid = 1'b0;
			pix       = {32'($urandom), 1'($urandom)};
			@(negedge clk);
		end
		pix_valid = 1'b1;
		pix       = b;
		do
			@(posedge clk);
		while (pix_stall !== 1'b0);
		made = blur_step(b, predicted);
		if (typed)
			due_results.push_back(want);
		else if (made)
			due_results.push_back(predicted);
		@(negedge clk);
	endtask

	// Stall the result side at random, except in the calm stretch.
	always @(negedge clk)
		res_stall <= !calm && ($urandom_range(99) < STALL_PCT);

	// Check every accepted result beat against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (due_results.size() == 0) begin
				flag_mismatch("result with nothing pending: no beat,",
					32'd0, {res.out_red, res.out_green, res.out_blue, res.out_alpha});
			end else begin
				next_want = due_results.pop_front();
				check_field("out_red",   next_want.out_red,   res.out_red);
				check_field("out_green", next_want.out_green, res.out_green);
				check_field("out_blue",  next_want.out_blue,  res.out_blue);
				check_field("out_alpha", next_want.out_alpha, res.out_alpha);
				check_field("frame_end", 8'(next_want.frame_end), 8'(res.frame_end));
			end
		end
	end

	// End the run if nothing moves on any port for too long.
	always @(posedge clk) begin
		if ((pix_valid && pix_stall === 1'b0) || (res_valid && !res_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_box_blur_3x3_core failed");
			$finish;
		end
	end

	initial begin
		int unsigned frame_no;
		int unsigned beats_sent;
		int unsigned n_pix;
		int unsigned n_flush;
		int unsigned mode;

		// hold reset, then release on a falling edge
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// walk the directed plan
		foreach (directed_plan[i]) begin
			case (directed_plan[i].kind)
				STEP_WRITE: write_reg(directed_plan[i].reg_idx, directed_plan[i].value);
				STEP_READ:  read_reg(directed_plan[i].reg_idx, directed_plan[i].value);
				default:    send_beat(directed_plan[i].beat, directed_plan[i].typed,
					directed_plan[i].want);
			endcase
		end

		// Random frames. Two runs hit the size limits: the widest line
		// (written as all ones, clamped, sent with no gaps or stalls and
		// flushed in part) and the tallest frame on a one-pixel line, cut
		// short after its first lines. The rest stay small.
		frame_no   = 0;
		beats_sent = 0;
		while (beats_sent < RANDOM_BEATS) begin
			calm = (frame_no == 2);
			if (frame_no == 2) begin
				write_reg(REG_IMAGE_WIDTH,  ($urandom & 32'hFFFF_F800) | 32'h7FF);
				write_reg(REG_IMAGE_HEIGHT, ($urandom & 32'hFFFF_E000) | 32'd1);
			end else if (frame_no == 5) begin
				write_reg(REG_IMAGE_WIDTH,  ($urandom & 32'hFFFF_F800) | 32'd1);
				write_reg(REG_IMAGE_HEIGHT, ($urandom & 32'hFFFF_E000) | 32'h1FFF);
			end else begin
				if ($urandom_range(99) < 60)
					write_reg(REG_IMAGE_WIDTH,
						($urandom & 32'hFFFF_F800) | pick_size(8, 40));
				if ($urandom_range(99) < 60)
					write_reg(REG_IMAGE_HEIGHT,
						($urandom & 32'hFFFF_E000) | pick_size(6, 16));
			end

			// mostly whole frames; some cut short, some with a short flush
			n_pix   = frame_w * frame_h;
			n_flush = frame_w + 1;
			mode    = $urandom_range(99);
			if (frame_no == 2) begin
				n_flush = WIDE_FLUSH;
			end else if (frame_no == 5) begin
				n_pix   = TALL_PIXELS;
				n_flush = 0;
			end else if (mode < 7) begin
				n_pix   = $urandom_range(1, n_pix);
				n_flush = 0;
			end else if (mode < 15) begin
				n_flush = $urandom_range(0, frame_w);
			end

			for (int k = 0; k < n_pix; k++) begin
				// stray drain among the pixels
				if ($urandom_range(99) < 6)
					send_beat({32'($urandom), 1'b1}, 1'b0, 33'd0);
				send_beat({32'($urandom), 1'b0}, 1'b0, 33'd0);
			end
			// flush with drains and surplus pixels alike
			for (int k = 0; k < n_flush; k++)
				send_beat({32'($urandom), 1'($urandom)}, 1'b0, 33'd0);

			beats_sent += n_pix + n_flush;
			frame_no++;
		end
		calm = 1'b0;

		// wait out the last results, then a little longer for strays
		settle_idle(DRAIN_CYCLES);
		if (bad_fields == 0 && due_results.size() == 0) begin
			$display("tb_box_blur_3x3_core passed");
		end else begin
			$display("tb_box_blur_3x3_core failed");
		end
		$finish;
	end

endmodule
